/* rtl/generational_tag_slot_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared assertion forms for the slot allocator, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_TAG_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_TAG_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define GTSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GTSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gtsa_pkg.sv */
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, codes, control types and the generation step.
// ----------------------------------------------------------------------------
package gtsa_pkg;

  localparam int SLOTS_DEF         = 64;
  localparam int PAYLOAD_WIDTH_DEF = 16;
  localparam int GEN_W             = 32;

  localparam logic [GEN_W-1:0] GEN_INIT = 32'd1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TAKE   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_STALE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } stat_t;

  // advance a generation, skipping zero on wrap
  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    return (g == '1) ? GEN_INIT : g + GEN_W'(1);
  endfunction

endpackage

/* rtl/gtsa_ctrl.sv */
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences the table clearing pass, word capture and the execute cycle.
// ----------------------------------------------------------------------------
module gtsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gtsa_pkg::stat_t   stat,
  output gtsa_pkg::cmd_t    cmd,
  output logic              busy
);

  gtsa_pkg::state_t state;
  gtsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtsa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      gtsa_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = gtsa_pkg::ST_IDLE;
        end
      end
      gtsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = gtsa_pkg::ST_EXEC;
        end
      end
      gtsa_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = gtsa_pkg::ST_IDLE;
      end
      default: begin
        state_next = gtsa_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/gtsa_datapath.sv */
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Slot memories, free-list head, tag check and result registers.
// ----------------------------------------------------------------------------
module gtsa_datapath #(
  parameter int SLOTS         = gtsa_pkg::SLOTS_DEF,
  parameter int PAYLOAD_WIDTH = gtsa_pkg::PAYLOAD_WIDTH_DEF,
  localparam int IDX_W        = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gtsa_pkg::cmd_t             cmd,
  output gtsa_pkg::stat_t            stat,
  input  logic                       mode,
  input  logic [PAYLOAD_WIDTH-1:0]   payload,
  input  logic [31:0]                tag_index,
  input  logic [gtsa_pkg::GEN_W-1:0] tag_generation,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [IDX_W-1:0]           slot_index,
  output logic [gtsa_pkg::GEN_W-1:0] slot_generation,
  output logic [PAYLOAD_WIDTH-1:0]   taken_payload
);

  localparam int GEN_W  = gtsa_pkg::GEN_W;
  localparam int LINK_W = IDX_W + 1;
  localparam int META_W = GEN_W + 1;

  // meta word: occupied mark above the generation
  logic [META_W-1:0]        meta_mem [SLOTS];
  logic [LINK_W-1:0]        link_mem [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem  [SLOTS];

  logic [LINK_W-1:0]        head;
  logic [IDX_W-1:0]         clr_addr;

  logic                     op_mode;
  logic [IDX_W-1:0]         op_idx;
  logic                     op_in_range;
  logic [GEN_W-1:0]         op_gen;
  logic [PAYLOAD_WIDTH-1:0] op_payload;

  logic [META_W-1:0]        rd_meta;
  logic [LINK_W-1:0]        rd_link;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  logic [IDX_W-1:0]         rd_addr;
  logic                     head_empty;
  logic                     meta_occ;
  logic [GEN_W-1:0]         meta_gen;
  logic                     ins_ok;
  logic                     take_ok;
  logic [LINK_W-1:0]        pop_head;

  assign rd_addr    = (mode == gtsa_pkg::MODE_TAKE) ? tag_index[IDX_W-1:0]
                                                    : head[IDX_W-1:0];
  assign head_empty = (head == LINK_W'(SLOTS));
  assign meta_occ   = rd_meta[GEN_W];
  assign meta_gen   = rd_meta[GEN_W-1:0];
  assign ins_ok     = (op_mode == gtsa_pkg::MODE_INSERT) && !head_empty;
  assign take_ok    = (op_mode == gtsa_pkg::MODE_TAKE) && op_in_range && meta_occ &&
                      (meta_gen == op_gen);
  assign pop_head   = (rd_link > LINK_W'(SLOTS)) ? LINK_W'(SLOTS) : rd_link;

  assign stat.clr_last = (clr_addr == IDX_W'(SLOTS - 1));

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_addr] <= {1'b0, gtsa_pkg::GEN_INIT};
      link_mem[clr_addr] <= LINK_W'(clr_addr) + LINK_W'(1);
    end else if (cmd.exec && ins_ok) begin
      meta_mem[op_idx] <= {1'b1, meta_gen};
      pay_mem[op_idx]  <= op_payload;
    end else if (cmd.exec && take_ok) begin
      meta_mem[op_idx] <= {1'b0, gtsa_pkg::next_gen(meta_gen)};
      link_mem[op_idx] <= head;
    end
    if (cmd.load) begin
      rd_meta <= meta_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
      rd_pay  <= pay_mem[rd_addr];
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode     <= mode;
      op_idx      <= rd_addr;
      op_in_range <= (tag_index < 32'(SLOTS));
      op_gen      <= tag_generation;
      op_payload  <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.clear) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      // pop on insert, push on take
      if (cmd.exec && ins_ok) begin
        head <= pop_head;
      end else if (cmd.exec && take_ok) begin
        head <= {1'b0, op_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_mode == gtsa_pkg::MODE_INSERT) begin
        status <= head_empty ? gtsa_pkg::STATUS_FULL : gtsa_pkg::STATUS_OK;
      end else begin
        status <= take_ok ? gtsa_pkg::STATUS_OK : gtsa_pkg::STATUS_STALE;
      end
      slot_index      <= ins_ok ? op_idx : '0;
      slot_generation <= ins_ok ? meta_gen : '0;
      taken_payload   <= take_ok ? rd_pay : '0;
    end
  end

endmodule

/* rtl/generational_tag_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// Generational tag slot allocator
// Result: start is taken, the word is captured, the execute state runs, then done is registered; no stall.
// Throughput: a new word is taken only in idle, not during the execute state of the slot memory read-modify-write.
// Reset: after rst falls, a clearing pass of SLOTS cycles holds busy high.
// ----------------------------------------------------------------------------
`include "generational_tag_slot_allocator_top_assert.svh"

module generational_tag_slot_allocator_top #(
  parameter int SLOTS         = gtsa_pkg::SLOTS_DEF,
  parameter int PAYLOAD_WIDTH = gtsa_pkg::PAYLOAD_WIDTH_DEF,
  localparam int IDX_W        = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [PAYLOAD_WIDTH-1:0]   payload,
  input  logic [31:0]                tag_index,
  input  logic [gtsa_pkg::GEN_W-1:0] tag_generation,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [IDX_W-1:0]           slot_index,
  output logic [gtsa_pkg::GEN_W-1:0] slot_generation,
  output logic [PAYLOAD_WIDTH-1:0]   taken_payload
);

  gtsa_pkg::cmd_t  cmd;
  gtsa_pkg::stat_t stat;

  gtsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  gtsa_datapath #(
    .SLOTS         (SLOTS),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .mode            (mode),
    .payload         (payload),
    .tag_index       (tag_index),
    .tag_generation  (tag_generation),
    .done            (done),
    .status          (status),
    .slot_index      (slot_index),
    .slot_generation (slot_generation),
    .taken_payload   (taken_payload)
  );

  `GTSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accept")
  `GTSA_ASSERT_NOW(a_done_from_accept, done, $past(start && !busy, 2), "done without accept")
  `GTSA_ASSERT_NOW(a_full_zero, done && (status == gtsa_pkg::STATUS_FULL), (slot_generation == '0) && (taken_payload == '0), "full result not zero")
  `GTSA_ASSERT_NOW(a_ins_gen_nonzero, done && (status == gtsa_pkg::STATUS_OK) && ($past(mode, 2) == gtsa_pkg::MODE_INSERT), slot_generation != '0, "zero generation issued")

endmodule

/* sim/tb_generational_tag_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives inserts and takes through the start/busy handshake and predicts each
// result word from a local copy of the slot table and free list. A scoreboard
// checks every done strobe against the oldest pending prediction. A short
// directed pass is followed by random fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module tb_generational_tag_slot_allocator_top;

  localparam int SLOTS       = gtsa_pkg::SLOTS_DEF;
  localparam int TOTAL_WORDS = 1150;
  localparam int QUIET_TAIL  = 150;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    gtsa_pkg::status_t status;
    logic [5:0]        slot_index;
    logic [31:0]       slot_generation;
    logic [15:0]       taken_payload;
  } slot_result_t;

  typedef struct packed {
    logic [31:0] idx;
    logic [31:0] gen;
  } tag_t;

  class slot_map_scoreboard;
    logic [15:0]  payload_mem[SLOTS];
    bit           occupied[SLOTS];
    logic [31:0]  gen_mem[SLOTS];
    logic [6:0]   link_mem[SLOTS];
    logic [6:0]   head_idx;
    slot_result_t pending[$];
    int           errors;
    int           checked;
    int           inserts_ok, inserts_full, takes_ok, takes_stale;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        payload_mem[i] = '0;
        occupied[i]    = 1'b0;
        gen_mem[i]     = 32'd1;
        link_mem[i]    = 7'(i + 1);
      end
      head_idx = '0;
    endfunction

    // predict the word for one accepted command and queue it
    function slot_result_t note_word(logic m, logic [15:0] pl, logic [31:0] ti,
                                     logic [31:0] tg);
      slot_result_t r;
      int unsigned  i;
      r = '0;
      r.status = gtsa_pkg::STATUS_OK;
      if (m == gtsa_pkg::MODE_INSERT) begin
        if (head_idx == 7'(SLOTS)) begin
          r.status = gtsa_pkg::STATUS_FULL;
          inserts_full++;
        end else begin
          i = head_idx;
          head_idx = link_mem[i];
          if (head_idx > 7'(SLOTS)) head_idx = 7'(SLOTS);
          payload_mem[i]    = pl;
          occupied[i]       = 1'b1;
          r.slot_index      = 6'(i);
          r.slot_generation = gen_mem[i];
          inserts_ok++;
        end
      end else begin
        if (ti >= SLOTS || !occupied[ti[5:0]] || gen_mem[ti[5:0]] != tg) begin
          r.status = gtsa_pkg::STATUS_STALE;
          takes_stale++;
        end else begin
          i = ti[5:0];
          r.taken_payload = payload_mem[i];
          occupied[i] = 1'b0;
          // skip zero on wrap
          gen_mem[i]  = (gen_mem[i] == 32'hFFFF_FFFF) ? 32'd1 : gen_mem[i] + 32'd1;
          link_mem[i] = head_idx;
          head_idx    = 7'(i);
          takes_ok++;
        end
      end
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result word with nothing pending: %s%0d slot=%0d gen=%h pl=%h",
                   $realtime, "status=", got.status, got.slot_index,
                   got.slot_generation, got.taken_payload);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.slot_generation !== want.slot_generation ||
          got.taken_payload !== want.taken_payload) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] mismatch: expected status=%0d slot=%0d gen=%h pl=%h,",
                    " got status=%0d slot=%0d gen=%h pl=%h"},
                   $realtime, want.status, want.slot_index, want.slot_generation,
                   want.taken_payload, got.status, got.slot_index, got.slot_generation,
                   got.taken_payload);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        mode = 1'b0;
  logic [15:0] payload = '0;
  logic [31:0] tag_index = '0;
  logic [31:0] tag_generation = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  slot_index;
  logic [31:0] slot_generation;
  logic [15:0] taken_payload;

  slot_map_scoreboard tracker = new();
  tag_t live_tags[$];
  tag_t retired_tags[$];
  int   words_sent = 0;
  int   quiet_cycles = 0;

  generational_tag_slot_allocator_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .payload        (payload),
    .tag_index      (tag_index),
    .tag_generation (tag_generation),
    .done           (done),
    .status         (status),
    .slot_index     (slot_index),
    .slot_generation(slot_generation),
    .taken_payload  (taken_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_result(slot_result_t'{gtsa_pkg::status_t'(status), slot_index,
                                          slot_generation, taken_payload});
  end

  // end the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_generational_tag_slot_allocator_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold start high until the word is taken; leave it high for a following word
  task automatic send_word(logic m, logic [15:0] pl, logic [31:0] ti, logic [31:0] tg);
    slot_result_t want;
    start          <= 1'b1;
    mode           <= m;
    payload        <= pl;
    tag_index      <= ti;
    tag_generation <= tg;
    do @(posedge clk); while (busy);
    want = tracker.note_word(m, pl, ti, tg);
    words_sent++;
    if (want.status == gtsa_pkg::STATUS_OK) begin
      if (m == gtsa_pkg::MODE_INSERT) begin
        live_tags.push_back(tag_t'{32'(want.slot_index), want.slot_generation});
      end else begin
        for (int k = 0; k < live_tags.size(); k++) begin
          if (live_tags[k].idx == ti) begin
            live_tags.delete(k);
            break;
          end
        end
        retired_tags.push_back(tag_t'{ti, tg});
        if (retired_tags.size() > SLOTS) void'(retired_tags.pop_front());
      end
    end
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // mostly valid tags, then old ones, corrupted generations and wild values
  task automatic pick_tag(output logic [31:0] ti, output logic [31:0] tg);
    int   roll;
    tag_t t;
    roll = $urandom_range(0, 99);
    if (roll < 70 && live_tags.size() > 0) begin
      t  = live_tags[$urandom_range(0, live_tags.size() - 1)];
      ti = t.idx;
      tg = t.gen;
    end else if (roll < 85 && retired_tags.size() > 0) begin
      t  = retired_tags[$urandom_range(0, retired_tags.size() - 1)];
      ti = t.idx;
      tg = t.gen;
    end else if (roll < 92 && live_tags.size() > 0) begin
      t  = live_tags[$urandom_range(0, live_tags.size() - 1)];
      ti = t.idx;
      tg = t.gen ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      ti = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70);
      tg = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
    end
  endtask

  initial begin
    int          phase_len;
    int          phase_kind;
    int          insert_pct;
    bit          idle_on;
    logic [31:0] ti;
    logic [31:0] tg;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: payload extremes, slot reuse, every stale flavor
    send_word(gtsa_pkg::MODE_INSERT, 16'h0000, 32'd0, 32'd0);
    send_word(gtsa_pkg::MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(gtsa_pkg::MODE_TAKE,   16'hFFFF, 32'd0, 32'd1);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd0, 32'd1);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd1, 32'd2);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd64, 32'd1);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd63, 32'd1);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd1, 32'd0);
    send_word(gtsa_pkg::MODE_INSERT, 16'hA5A5, 32'd0, 32'd0);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd1, 32'd1);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'd0, 32'd2);
    send_word(gtsa_pkg::MODE_INSERT, 16'h5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pause(3);
    send_word(gtsa_pkg::MODE_TAKE,   16'h1234, 32'd0, 32'd3);
    send_word(gtsa_pkg::MODE_TAKE,   16'h0000, 32'h8000_0000, 32'h8000_0000);

    // random: fill phases drive the table full, drain phases empty it
    while (words_sent < TOTAL_WORDS) begin
      phase_len  = $urandom_range(40, 100);
      phase_kind = $urandom_range(0, 2);
      idle_on    = $urandom_range(0, 3) != 0;
      insert_pct = (phase_kind == 0) ? 95 : (phase_kind == 1) ? 10 : 50;
      for (int n = 0; n < phase_len && words_sent < TOTAL_WORDS; n++) begin
        if (idle_on && words_sent < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
          pause($urandom_range(1, 16));
        if ($urandom_range(0, 99) < insert_pct) begin
          send_word(gtsa_pkg::MODE_INSERT, 16'($urandom), $urandom, $urandom);
        end else begin
          pick_tag(ti, tg);
          send_word(gtsa_pkg::MODE_TAKE, 16'($urandom), ti, tg);
        end
      end
    end
    start <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words, checked %0d results, %0d errors.",
             words_sent, tracker.checked, tracker.errors);
    $display("Inserts ok %0d / full %0d, takes ok %0d / stale %0d.",
             tracker.inserts_ok, tracker.inserts_full, tracker.takes_ok,
             tracker.takes_stale);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb_generational_tag_slot_allocator_top: PASS");
    end else begin
      $display("tb_generational_tag_slot_allocator_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/gtsa_pkg.sv
rtl/gtsa_ctrl.sv
rtl/gtsa_datapath.sv
rtl/generational_tag_slot_allocator_top.sv
sim/tb_generational_tag_slot_allocator_top.sv
